>>> design/kffc_pkg.sv
// Package for the keypad four-function calculator.
// Holds the data widths, key codes, operator codes and the shared adder request type.
// No dependencies.
`default_nettype none

package kffc_pkg;

  // Width of the arithmetic word and of the displayed value.
  localparam int unsigned DataWidth    = 32;
  localparam int unsigned DisplayWidth = 32;
  // The shared adder is one bit wider so that the divider can detect a borrow.
  localparam int unsigned AluWidth     = DataWidth + 1;
  localparam int unsigned CntWidth     = $clog2(DataWidth);

  // Keypad characters.
  localparam logic [7:0] Key0     = 8'h30;
  localparam logic [7:0] Key9     = 8'h39;
  localparam logic [7:0] KeyPlus  = 8'h2B;
  localparam logic [7:0] KeyMinus = 8'h2D;
  localparam logic [7:0] KeyTimes = 8'h2A;
  localparam logic [7:0] KeySlash = 8'h2F;
  localparam logic [7:0] KeyEqual = 8'h3D;
  localparam logic [7:0] KeyClrLo = 8'h63;
  localparam logic [7:0] KeyClrUp = 8'h43;

  // Pending operator codes.
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_e;

  // Operands and mode for the shared adder/subtractor.
  typedef struct packed {
    logic [AluWidth-1:0] a;
    logic [AluWidth-1:0] b;
    logic                sub;
  } addsub_req_t;

endpackage

`default_nettype wire

>>> design/kffc_addsub.sv
// Shared adder/subtractor used by every arithmetic step of the calculator.
// Depends on kffc_pkg for the operand width and request type.
`default_nettype none

module kffc_addsub import kffc_pkg::*; (
  input  addsub_req_t         req_i,
  output logic [AluWidth-1:0] sum_o,
  output logic                carry_o
);

  logic [AluWidth:0] full;

  // Subtraction is a plus the inverted b plus one; the carry out means no borrow.
  assign full = {1'b0, req_i.a}
              + {1'b0, (req_i.sub ? ~req_i.b : req_i.b)}
              + {{AluWidth{1'b0}}, req_i.sub};

  assign sum_o   = full[AluWidth-1:0];
  assign carry_o = full[AluWidth];

endmodule

`default_nettype wire

>>> design/keypad_four_function_calculator_unit.sv
// Top level of the keypad four-function calculator: sequencer, state and output register.
// Depends on kffc_pkg and instantiates kffc_addsub.
//
// Usage:
//   The input channel (in_valid_i, in_ready_o, key_char_i) takes one ASCII key per
//   transfer. The output channel (out_valid_o, out_ready_i, accepted_o,
//   display_value_o, error_flag_o) returns exactly one result per key.
//   One adder/subtractor does all arithmetic under a small sequencer, so one key
//   is worked on at a time and in_ready_o is high only while the sequencer idles.
//   Clear, operator without a fresh entry, add, subtract and rejected keys finish
//   in the decode step; a digit takes two adder passes (times ten, then plus
//   digit); multiply takes one shift-add pass per bit; divide takes two magnitude
//   passes, one restoring step per bit and one sign pass. Each result then goes
//   through the done state to the output register. A new key may be accepted in
//   the cycle after the result is loaded into the output register.
//   When the receiver stalls, a finished result waits in the output register while
//   the next key is taken and worked on; that key's result is held until the
//   register is free.
//   Reset clears the accumulator, entry, pending operator, error flag and output
//   valid.
`default_nettype none

module keypad_four_function_calculator_unit import kffc_pkg::*; (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire        [7:0]                key_char_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic                            accepted_o,
  output logic signed [DisplayWidth-1:0]  display_value_o,
  output logic                            error_flag_o
);

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b0000000001,
    ST_DECODE    = 10'b0000000010,
    ST_DIG_MUL   = 10'b0000000100,
    ST_DIG_ADD   = 10'b0000001000,
    ST_MUL_STEP  = 10'b0000010000,
    ST_DIV_ABS_N = 10'b0000100000,
    ST_DIV_ABS_D = 10'b0001000000,
    ST_DIV_STEP  = 10'b0010000000,
    ST_DIV_SIGN  = 10'b0100000000,
    ST_DONE      = 10'b1000000000
  } state_e;

  state_e                state_q, state_d;
  logic [DataWidth-1:0]  acc_q, acc_d;
  logic [DataWidth-1:0]  entry_q, entry_d;
  logic                  pend_q, pend_d;
  op_e                   op_q, op_d;
  logic                  err_q, err_d;
  logic                  key_ok_q, key_ok_d;
  logic [7:0]            key_q;
  logic [DataWidth-1:0]  work_q, work_d;
  logic [DataWidth-1:0]  aux_q, aux_d;
  logic [DataWidth-1:0]  rem_q, rem_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_acc_q, out_acc_d;
  logic [DisplayWidth-1:0] out_disp_q, out_disp_d;
  logic                  out_err_q, out_err_d;

  addsub_req_t           alu_req;
  logic [AluWidth-1:0]   alu_sum;
  logic                  alu_carry;

  logic                  is_digit;
  logic                  is_clear;
  logic                  is_op;
  op_e                   new_op;
  logic                  cnt_last;

  kffc_addsub u_addsub (
    .req_i   (alu_req),
    .sum_o   (alu_sum),
    .carry_o (alu_carry)
  );

  // Key classification from the captured character.
  assign is_digit = (key_q >= Key0) && (key_q <= Key9);
  assign is_clear = (key_q == KeyClrLo) || (key_q == KeyClrUp);
  assign cnt_last = (cnt_q == CntWidth'(DataWidth - 1));

  always_comb begin
    is_op  = 1'b1;
    new_op = OP_NONE;
    case (key_q)
      KeyPlus:  new_op = OP_ADD;
      KeyMinus: new_op = OP_SUB;
      KeyTimes: new_op = OP_MUL;
      KeySlash: new_op = OP_DIV;
      KeyEqual: new_op = OP_NONE;
      default:  is_op  = 1'b0;
    endcase
  end

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    entry_d     = entry_q;
    pend_d      = pend_q;
    op_d        = op_q;
    err_d       = err_q;
    key_ok_d    = key_ok_q;
    work_d      = work_q;
    aux_d       = aux_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_acc_d   = out_acc_q;
    out_disp_d  = out_disp_q;
    out_err_d   = out_err_q;
    alu_req     = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        // Add and subtract finish here in one adder pass.
        alu_req.a   = {1'b0, acc_q};
        alu_req.b   = {1'b0, entry_q};
        alu_req.sub = (op_q == OP_SUB);
        key_ok_d    = is_clear || is_digit || is_op;
        state_d     = ST_DONE;
        if (is_clear) begin
          acc_d   = '0;
          entry_d = '0;
          pend_d  = 1'b0;
          op_d    = OP_NONE;
          err_d   = 1'b0;
        end else if (is_digit && !err_q) begin
          work_d  = pend_q ? entry_q : '0;
          state_d = ST_DIG_MUL;
        end else if (is_op && !err_q) begin
          if (!pend_q) begin
            op_d = new_op;
          end else begin
            case (op_q)
              OP_NONE: begin
                acc_d  = entry_q;
                pend_d = 1'b0;
                op_d   = new_op;
              end
              OP_ADD, OP_SUB: begin
                acc_d  = alu_sum[DataWidth-1:0];
                pend_d = 1'b0;
                op_d   = new_op;
              end
              OP_MUL: begin
                aux_d   = acc_q;
                work_d  = entry_q;
                acc_d   = '0;
                cnt_d   = '0;
                state_d = ST_MUL_STEP;
              end
              OP_DIV: begin
                if (entry_q == '0) begin
                  // Divide by zero: set the error and drop the new operator.
                  err_d  = 1'b1;
                  pend_d = 1'b0;
                end else begin
                  state_d = ST_DIV_ABS_N;
                end
              end
              default: begin
                pend_d = 1'b0;
                op_d   = new_op;
              end
            endcase
          end
        end
      end

      ST_DIG_MUL: begin
        // Entry times ten as (x << 3) + (x << 1).
        alu_req.a = {1'b0, work_q[DataWidth-4:0], 3'b000};
        alu_req.b = {1'b0, work_q[DataWidth-2:0], 1'b0};
        work_d    = alu_sum[DataWidth-1:0];
        state_d   = ST_DIG_ADD;
      end

      ST_DIG_ADD: begin
        alu_req.a = {1'b0, work_q};
        alu_req.b = {{(AluWidth-4){1'b0}}, key_q[3:0]};
        entry_d   = alu_sum[DataWidth-1:0];
        pend_d    = 1'b1;
        state_d   = ST_DONE;
      end

      ST_MUL_STEP: begin
        // Shift-add multiply; the product builds in the accumulator.
        alu_req.a = {1'b0, acc_q};
        alu_req.b = work_q[0] ? {1'b0, aux_q} : '0;
        acc_d     = alu_sum[DataWidth-1:0];
        aux_d     = {aux_q[DataWidth-2:0], 1'b0};
        work_d    = {1'b0, work_q[DataWidth-1:1]};
        cnt_d     = cnt_q + 1'b1;
        if (cnt_last) begin
          pend_d  = 1'b0;
          op_d    = new_op;
          state_d = ST_DONE;
        end
      end

      ST_DIV_ABS_N: begin
        alu_req.b   = {1'b0, acc_q};
        alu_req.sub = acc_q[DataWidth-1];
        work_d      = alu_sum[DataWidth-1:0];
        state_d     = ST_DIV_ABS_D;
      end

      ST_DIV_ABS_D: begin
        alu_req.b   = {1'b0, entry_q};
        alu_req.sub = entry_q[DataWidth-1];
        aux_d       = alu_sum[DataWidth-1:0];
        rem_d       = '0;
        cnt_d       = '0;
        state_d     = ST_DIV_STEP;
      end

      ST_DIV_STEP: begin
        // Restoring division: the quotient shifts into the work register.
        alu_req.a   = {rem_q, work_q[DataWidth-1]};
        alu_req.b   = {1'b0, aux_q};
        alu_req.sub = 1'b1;
        if (alu_carry) begin
          rem_d = alu_sum[DataWidth-1:0];
        end else begin
          rem_d = {rem_q[DataWidth-2:0], work_q[DataWidth-1]};
        end
        work_d = {work_q[DataWidth-2:0], alu_carry};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_last) begin
          state_d = ST_DIV_SIGN;
        end
      end

      ST_DIV_SIGN: begin
        // Negate the quotient when the operand signs differ.
        alu_req.b   = {1'b0, work_q};
        alu_req.sub = acc_q[DataWidth-1] ^ entry_q[DataWidth-1];
        acc_d       = alu_sum[DataWidth-1:0];
        pend_d      = 1'b0;
        op_d        = new_op;
        state_d     = ST_DONE;
      end

      ST_DONE: begin
        // Load the result once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_acc_d   = key_ok_q;
          out_disp_d  = DisplayWidth'(pend_q ? entry_q : acc_q);
          out_err_d   = err_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      entry_q     <= '0;
      pend_q      <= 1'b0;
      op_q        <= OP_NONE;
      err_q       <= 1'b0;
      key_ok_q    <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      entry_q     <= entry_d;
      pend_q      <= pend_d;
      op_q        <= op_d;
      err_q       <= err_d;
      key_ok_q    <= key_ok_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      key_q <= key_char_i;
    end
    work_q     <= work_d;
    aux_q      <= aux_d;
    rem_q      <= rem_d;
    out_acc_q  <= out_acc_d;
    out_disp_q <= out_disp_d;
    out_err_q  <= out_err_d;
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign accepted_o      = out_acc_q;
  assign display_value_o = out_disp_q;
  assign error_flag_o    = out_err_q;

`ifndef SYNTHESIS
  // An input transfer always starts decoding in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DECODE))
    else $error("input transfer did not start decode");

  // The divider never runs with a zero divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_STEP) |-> (aux_q != '0))
    else $error("division step with zero divisor");

  // While in error, any key but clear leaves the accumulator alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECODE && err_q && !is_clear) |=> ($stable(acc_q) && err_q))
    else $error("key changed state during error");
`endif

endmodule

`default_nettype wire
